// ===== src/asfd_pkg.sv =====
// Shared constants, types and codes for the air sensor frame decoder.
package asfd_pkg;

    localparam int BYTE_W      = 8;
    localparam int WORD_W      = 16;
    localparam int TENTHS_W    = 12;
    localparam int FRAME_LEN   = 17;
    localparam int STORE_DEPTH = 14;
    localparam int POS_W       = 5;
    localparam int STORE_IDX_W = 4;
    localparam int STATUS_W    = 2;
    localparam int CFG_INDEX_W = 2;

    // Frame positions with special meaning
    localparam logic [POS_W-1:0] POS_HUNT     = POS_W'(0);
    localparam logic [POS_W-1:0] POS_TYPE     = POS_W'(1);
    localparam logic [POS_W-1:0] POS_DATA0    = POS_W'(2);
    localparam logic [POS_W-1:0] POS_CHECKSUM = POS_W'(FRAME_LEN - 1);

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_CHECKSUM = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FORMAT   = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_START_BYTE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TYPE_BYTE  = 2'd1;

    // Reset values of the configuration registers
    localparam logic [BYTE_W-1:0] START_BYTE_RST = 8'h3c;
    localparam logic [BYTE_W-1:0] TYPE_BYTE_RST  = 8'h02;

    // Temperature codes above this value stand for negative readings
    localparam logic [TENTHS_W-1:0] NEG_OFFSET = 12'd1280;

    // Payload bytes 2..15 of a frame, entry 0 holds frame byte 2
    typedef logic [STORE_DEPTH-1:0][BYTE_W-1:0] frame_bytes_t;

    typedef struct packed {
        logic        [WORD_W-1:0]   co2_ppm;
        logic        [WORD_W-1:0]   formaldehyde;
        logic        [WORD_W-1:0]   tvoc;
        logic        [WORD_W-1:0]   pm_small;
        logic        [WORD_W-1:0]   pm_large;
        logic signed [TENTHS_W-1:0] temperature_tenths;
        logic        [TENTHS_W-1:0] humidity_tenths;
    } reading_t;

endpackage

// ===== src/asfd_decode.sv =====
// Conversion of stored frame bytes into sensor readings.
module asfd_decode
    import asfd_pkg::*;
(
    input  frame_bytes_t frame_bytes,
    output reading_t     reading
);

    logic [TENTHS_W-1:0] temp_code;
    logic [TENTHS_W-1:0] hum_code;

    // Form b_hi * 10 + b_lo
    function automatic logic [TENTHS_W-1:0] tens_plus(input logic [BYTE_W-1:0] hi,
                                                      input logic [BYTE_W-1:0] lo);
        logic [TENTHS_W-1:0] hi_w;
        hi_w = TENTHS_W'(hi);
        return (hi_w << 3) + (hi_w << 1) + TENTHS_W'(lo);
    endfunction

    assign temp_code = tens_plus(frame_bytes[10], frame_bytes[11]);
    assign hum_code  = tens_plus(frame_bytes[12], frame_bytes[13]);

    // Assemble big-endian words
    assign reading.co2_ppm      = {frame_bytes[0], frame_bytes[1]};
    assign reading.formaldehyde = {frame_bytes[2], frame_bytes[3]};
    assign reading.tvoc         = {frame_bytes[4], frame_bytes[5]};
    assign reading.pm_small     = {frame_bytes[6], frame_bytes[7]};
    assign reading.pm_large     = {frame_bytes[8], frame_bytes[9]};

    // Fold codes above the offset into negative temperatures
    assign reading.temperature_tenths = (temp_code > NEG_OFFSET)
                                        ? $signed(NEG_OFFSET - temp_code)
                                        : $signed(temp_code);
    assign reading.humidity_tenths    = hum_code;

endmodule

// ===== src/air_sensor_frame_decoder_unit.sv =====
// Top level of the air sensor frame decoder: framing, checksum and result register.
//
// The block takes one received byte per clock cycle and produces one result per
// frame or per rejected type byte. Each byte is handled in the cycle it is
// accepted: framing position, running checksum and the payload bytes are updated
// in registers, and the result appears in the output register in the cycle after
// the checksum byte (or the wrong type byte) is accepted. Input is taken every
// cycle as long as the output register is empty or is being drained in that
// cycle, so a stalled consumer holds off new bytes only while a result waits.
// Configuration writes are always accepted and take effect for the next byte.
module air_sensor_frame_decoder_unit
    import asfd_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    // Configuration write port
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_INDEX_W-1:0]     cfg_index,
    input  logic [BYTE_W-1:0]          cfg_data,
    // Byte input
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [BYTE_W-1:0]          rx_byte,
    // Result output
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [STATUS_W-1:0]        status,
    output logic [WORD_W-1:0]          co2_ppm,
    output logic [WORD_W-1:0]          formaldehyde,
    output logic [WORD_W-1:0]          tvoc,
    output logic [WORD_W-1:0]          pm_small,
    output logic [WORD_W-1:0]          pm_large,
    output logic signed [TENTHS_W-1:0] temperature_tenths,
    output logic [TENTHS_W-1:0]        humidity_tenths
);

    logic [BYTE_W-1:0]   start_byte_reg;
    logic [BYTE_W-1:0]   type_byte_reg;
    logic [POS_W-1:0]    pos_reg;
    logic [POS_W-1:0]    pos_next;
    logic [BYTE_W-1:0]   sum_reg;
    logic [BYTE_W-1:0]   sum_next;
    frame_bytes_t        store_reg;
    logic                store_we;
    logic [STORE_IDX_W-1:0] store_idx;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [STATUS_W-1:0] status_reg;
    logic [STATUS_W-1:0] status_next;
    reading_t            reading_reg;
    reading_t            reading;
    logic                emit;
    logic                accept;

    assign cfg_ready = 1'b1;
    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_byte_reg <= START_BYTE_RST;
            type_byte_reg  <= TYPE_BYTE_RST;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == CFG_START_BYTE)
            begin
                start_byte_reg <= cfg_data;
            end
            else if (cfg_index == CFG_TYPE_BYTE)
            begin
                type_byte_reg <= cfg_data;
            end
        end
    end

    // Advance the frame position and checksum for one accepted byte, write payload bytes and raise results
    always_comb
    begin
        pos_next    = pos_reg;
        sum_next    = sum_reg;
        emit        = 1'b0;
        status_next = ST_OK;
        store_we    = 1'b0;
        store_idx   = STORE_IDX_W'(pos_reg - POS_DATA0);
        if (accept)
        begin
            case (pos_reg)
                POS_HUNT:
                begin
                    if (rx_byte == start_byte_reg)
                    begin
                        sum_next = rx_byte;
                        pos_next = POS_TYPE;
                    end
                end
                POS_TYPE:
                begin
                    if (rx_byte != type_byte_reg)
                    begin
                        pos_next    = POS_HUNT;
                        sum_next    = '0;
                        emit        = 1'b1;
                        status_next = ST_FORMAT;
                    end
                    else
                    begin
                        sum_next = sum_reg + rx_byte;
                        pos_next = POS_DATA0;
                    end
                end
                POS_CHECKSUM:
                begin
                    pos_next    = POS_HUNT;
                    sum_next    = '0;
                    emit        = 1'b1;
                    status_next = (rx_byte == sum_reg) ? ST_OK : ST_CHECKSUM;
                end
                default:
                begin
                    if (pos_reg > POS_CHECKSUM)
                    begin
                        // Out-of-range position: drop back to hunting
                        pos_next = POS_HUNT;
                        if (rx_byte == start_byte_reg)
                        begin
                            sum_next = rx_byte;
                            pos_next = POS_TYPE;
                        end
                    end
                    else
                    begin
                        store_we = 1'b1;
                        sum_next = sum_reg + rx_byte;
                        pos_next = pos_reg + POS_W'(1);
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= POS_HUNT;
            sum_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
            sum_reg <= sum_next;
        end
    end

    // Payload byte store
    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            store_reg[store_idx] <= rx_byte;
        end
    end

    asfd_decode u_decode (
        .frame_bytes (store_reg),
        .reading     (reading)
    );

    // Result register: hold until taken
    assign out_valid_next = emit ? 1'b1 : (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            status_reg  <= status_next;
            reading_reg <= (status_next == ST_OK) ? reading : '0;
        end
    end

    assign out_valid          = out_valid_reg;
    assign status             = status_reg;
    assign co2_ppm            = reading_reg.co2_ppm;
    assign formaldehyde       = reading_reg.formaldehyde;
    assign tvoc               = reading_reg.tvoc;
    assign pm_small           = reading_reg.pm_small;
    assign pm_large           = reading_reg.pm_large;
    assign temperature_tenths = reading_reg.temperature_tenths;
    assign humidity_tenths    = reading_reg.humidity_tenths;

    // A wrong type byte is reported in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && pos_reg == POS_TYPE && rx_byte != type_byte_reg
        |=> out_valid && status == ST_FORMAT)
    else $error("wrong type byte not reported");

    // The checksum byte always yields a result
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && pos_reg == POS_CHECKSUM |=> out_valid && pos_reg == POS_HUNT)
    else $error("checksum byte did not close the frame");

    // Rejected results carry no readings
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> co2_ppm == '0 && pm_large == '0
        && humidity_tenths == '0 && temperature_tenths == '0)
    else $error("readings leak into a rejected result");

    // Frame position never leaves its range
    assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_CHECKSUM)
    else $error("frame position out of range");

endmodule
